// ===== design/scfe_pkg.sv =====
// Package: payload types, frame constants and shared types for the sum checksum frame encoder.
`default_nettype none
package scfe_pkg;

  localparam int MAX_PAYLOAD = 2048;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 2);
  localparam int LEN_W       = 12;
  localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [7:0] HEAD_BYTE     = 8'h7E;
  localparam logic [7:0] TAIL_HIGH     = 8'h0D;
  localparam logic [7:0] TAIL_LOW      = 8'h0A;
  localparam logic [7:0] FC_RESET      = 8'h04;
  localparam logic [LEN_W-1:0] LEN_ADD = LEN_W'(3);

  // Output slot positions within one item's burst.
  localparam int SLOT_HEAD   = 0;
  localparam int SLOT_LEN_HI = 1;
  localparam int SLOT_LEN_LO = 2;
  localparam int SLOT_FC     = 3;
  localparam int SLOT_SEQ    = 4;
  localparam int SLOT_PAY    = 5;
  localparam int SLOT_SUM    = 6;
  localparam int SLOT_TAIL_H = 7;
  localparam int SLOT_TAIL_L = 8;
  localparam int NUM_SLOTS   = 9;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             first_of_frame;
    logic             last_of_frame;
    logic [LEN_W-1:0] payload_length;
  } scfe_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       length_mismatch;
  } scfe_out_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [15:0]          flen;
    logic [7:0]           fc;
    logic [7:0]           seq;
    logic [7:0]           pay;
    logic [7:0]           sum;
    logic                 mis;
  } scfe_job_t;

endpackage
`default_nettype wire

// ===== design/scfe_emit.sv =====
// Burst register and byte sequencer: sends the words of one item in slot order.
`default_nettype none
module scfe_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire scfe_pkg::scfe_job_t job_in,
  output logic                   busy,
  output logic                   last_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output scfe_pkg::scfe_out_t    out_data
);
  import scfe_pkg::*;

  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  scfe_job_t            job_r;
  logic [NUM_SLOTS-1:0] low;
  logic                 out_acc;

  assign low       = mask_r & (~mask_r + NUM_SLOTS'(1));
  assign busy      = |mask_r;
  assign last_word = ((mask_r & ~low) == '0);
  assign out_valid = busy;
  assign out_acc   = busy & ~out_stall;

  always_comb begin
    mask_nxt = mask_r;
    if (out_acc) begin
      mask_nxt = mask_r & ~low;
    end
    if (load) begin
      mask_nxt = job_in.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
  end

  always_comb begin
    out_data = '0;
    if (low[SLOT_HEAD]) begin
      out_data.frame_byte = HEAD_BYTE;
    end else if (low[SLOT_LEN_HI]) begin
      out_data.frame_byte = job_r.flen[15:8];
    end else if (low[SLOT_LEN_LO]) begin
      out_data.frame_byte = job_r.flen[7:0];
    end else if (low[SLOT_FC]) begin
      out_data.frame_byte = job_r.fc;
    end else if (low[SLOT_SEQ]) begin
      out_data.frame_byte = job_r.seq;
    end else if (low[SLOT_PAY]) begin
      out_data.frame_byte = job_r.pay;
    end else if (low[SLOT_SUM]) begin
      out_data.frame_byte = job_r.sum;
    end else if (low[SLOT_TAIL_H]) begin
      out_data.frame_byte = TAIL_HIGH;
    end else if (low[SLOT_TAIL_L]) begin
      out_data.frame_byte      = TAIL_LOW;
      out_data.frame_end       = 1'b1;
      out_data.length_mismatch = job_r.mis;
    end
  end

endmodule
`default_nettype wire

// ===== design/sum_checksum_frame_encoder_top.sv =====
// Top level: frame state, checksum and length tracking, burst hand-off to the sequencer.
//
//   port group   dir  words          handshake
//   in_*         in   scfe_in_t      in_valid / in_stall
//   out_*        out  scfe_out_t     out_valid / out_stall
//   cfg_*        in   function code  cfg_wr_en, no wait
//
// Each accepted word yields 0 to 9 output words, sent one per cycle while out_stall is low.
// A body word yields one output word, and the input is taken again as a burst's last word leaves,
// so body words stream back to back while out_stall is low. A header (5 extra words) or a tail
// (3 extra) holds in_stall high until the burst's last word is taken. Frame state updates on input
// accept; the burst register holds its words. Synchronous active-low reset; function code resets to 0x04.
`default_nettype none
module sum_checksum_frame_encoder_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire scfe_pkg::scfe_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output scfe_pkg::scfe_out_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data
);
  import scfe_pkg::*;

  logic [7:0]       fc_r;
  logic [7:0]       seq_r, seq_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] decl_r, decl_nxt;
  logic             open_r, open_nxt;

  logic             busy, last_word, in_acc;
  logic [7:0]       sum_base;
  logic [CNT_W-1:0] cnt_base;
  logic             emit_pay;
  logic [LEN_W-1:0] flen12;
  scfe_job_t        job;

  assign in_stall = busy & ~(last_word & ~out_stall);
  assign in_acc   = in_valid & ~in_stall;
  assign flen12   = in_data.payload_length + LEN_ADD;

  always_comb begin
    seq_nxt  = seq_r;
    decl_nxt = decl_r;
    open_nxt = open_r;
    sum_base = sum_r;
    cnt_base = cnt_r;
    if (in_data.first_of_frame) begin
      seq_nxt  = seq_r + 8'd1;
      decl_nxt = in_data.payload_length;
      open_nxt = 1'b1;
      sum_base = fc_r + seq_nxt;
      cnt_base = '0;
    end
    emit_pay = open_nxt && (CMP_W'(cnt_base) < CMP_W'(MAX_PAYLOAD));
    sum_nxt  = emit_pay ? (sum_base + in_data.payload_byte) : sum_base;
    cnt_nxt  = (CMP_W'(cnt_base) <= CMP_W'(MAX_PAYLOAD)) ? (cnt_base + CNT_W'(1)) : cnt_base;
    if (!open_nxt) begin
      sum_nxt = sum_r;
      cnt_nxt = cnt_r;
    end
    if (open_nxt && in_data.last_of_frame) begin
      open_nxt = 1'b0;
    end

    job      = '0;
    job.flen = 16'(flen12) + 16'(in_data.payload_length > (LEN_W'((1 << LEN_W) - 1) - LEN_ADD))
               * 16'(1 << LEN_W);
    job.fc   = fc_r;
    job.seq  = seq_nxt;
    job.pay  = in_data.payload_byte;
    job.sum  = sum_nxt;
    job.mis  = (CMP_W'(cnt_nxt) != CMP_W'(decl_nxt));
    if (in_data.first_of_frame) begin
      job.mask[SLOT_HEAD]   = 1'b1;
      job.mask[SLOT_LEN_HI] = 1'b1;
      job.mask[SLOT_LEN_LO] = 1'b1;
      job.mask[SLOT_FC]     = 1'b1;
      job.mask[SLOT_SEQ]    = 1'b1;
    end
    job.mask[SLOT_PAY] = emit_pay;
    if ((open_r || in_data.first_of_frame) && in_data.last_of_frame) begin
      job.mask[SLOT_SUM]    = 1'b1;
      job.mask[SLOT_TAIL_H] = 1'b1;
      job.mask[SLOT_TAIL_L] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= FC_RESET;
      seq_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      decl_r <= '0;
      open_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fc_r <= cfg_wr_data;
      end
      if (in_acc) begin
        seq_r  <= seq_nxt;
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        decl_r <= decl_nxt;
        open_r <= open_nxt;
      end
    end
  end

  scfe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .job_in    (job),
    .busy      (busy),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
